>>> hdl/krt_pkg.sv
// Shared types and codes for the keyed record table.
package krt_pkg;

    // Mode codes of a request word
    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_LIST   = 3'd1;
    localparam logic [2:0] MODE_QUERY  = 3'd2;
    localparam logic [2:0] MODE_MODIFY = 3'd3;
    localparam logic [2:0] MODE_DELETE = 3'd4;

    // Status codes of a response word
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] key;
        logic [31:0]        value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] rec_key;
        logic [31:0]        rec_value;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        value;
    } rec_t;

endpackage

>>> hdl/krt_store.sv
// Record memory: one write port, one read port with registered read data.
module krt_store
    import krt_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  rec_t             wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output rec_t             rd_data
);

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    // Write one record
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one record, hold it until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/keyed_record_table.sv
// Keyed record table: packed record list with insert, list, query, modify and delete.
// Query, modify and delete search the records in order; delete then shifts later records down
// one by one after its response is sent; list reads and sends each record in turn.
// One request at a time: a new request is taken only in idle, and output stalls hold the
// sequencer in its emit state until the response register frees up.
// Reset clears the record count and all control; memory contents are not cleared.
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int MAX_RECORDS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SRCH_RD  = 4'd2;
    localparam logic [3:0] S_SRCH_CMP = 4'd3;
    localparam logic [3:0] S_LS_RD    = 4'd4;
    localparam logic [3:0] S_LS_GET   = 4'd5;
    localparam logic [3:0] S_SH_RD    = 4'd6;
    localparam logic [3:0] S_SH_WR    = 4'd7;
    localparam logic [3:0] S_EMIT     = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [3:0]       after_reg, after_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    req_t             item_reg, item_next;
    rsp_t             res_reg, res_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    rec_t             rd_data;

    logic [CNT_W-1:0] idx_inc;
    logic             rsp_free;

    krt_store #(
        .DEPTH (MAX_RECORDS),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequence one request through the record memory
    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IDX_W-1:0];
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];

        // Drop the response word once taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                idx_next   = '0;
                after_next = S_IDLE;
                res_next   = '{status: ST_OK, rec_key: '0, rec_value: '0, last: 1'b1};
                if (item_reg.mode > MODE_DELETE)
                begin
                    state_next = S_IDLE;
                end
                else if (item_reg.mode == MODE_INSERT)
                begin
                    if (count_reg == CNT_W'(MAX_RECORDS))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        wr_en              = 1'b1;
                        wr_addr            = count_reg[IDX_W-1:0];
                        wr_data.key        = item_reg.key;
                        wr_data.value      = item_reg.value;
                        count_next         = count_reg + CNT_W'(1);
                        res_next.rec_key   = item_reg.key;
                        res_next.rec_value = item_reg.value;
                    end
                    state_next = S_EMIT;
                end
                else if (count_reg == '0)
                begin
                    res_next.status = ST_EMPTY;
                    state_next      = S_EMIT;
                end
                else if (item_reg.mode == MODE_LIST)
                begin
                    state_next = S_LS_RD;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end

            // Search: read a record, then compare its key
            S_SRCH_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_SRCH_CMP;
            end

            S_SRCH_CMP:
            begin
                if (rd_data.key == item_reg.key)
                begin
                    res_next.rec_key   = rd_data.key;
                    res_next.rec_value = rd_data.value;
                    state_next         = S_EMIT;
                    if (item_reg.mode == MODE_MODIFY)
                    begin
                        wr_en              = 1'b1;
                        wr_data.key        = rd_data.key;
                        wr_data.value      = item_reg.value;
                        res_next.rec_value = item_reg.value;
                    end
                    else if (item_reg.mode == MODE_DELETE)
                    begin
                        after_next = S_SH_RD;
                    end
                end
                else if (idx_inc == count_reg)
                begin
                    res_next.status = ST_MISSING;
                    state_next      = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SRCH_RD;
                end
            end

            // List: read each record in turn and send it
            S_LS_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_LS_GET;
            end

            S_LS_GET:
            begin
                res_next.rec_key   = rd_data.key;
                res_next.rec_value = rd_data.value;
                res_next.last      = (idx_inc == count_reg);
                after_next         = (idx_inc == count_reg) ? S_IDLE : S_LS_RD;
                idx_next           = idx_inc;
                state_next         = S_EMIT;
            end

            // Delete: move later records down by one
            S_SH_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[IDX_W-1:0];
                    state_next = S_SH_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_IDLE;
                end
            end

            S_SH_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_inc;
                state_next = S_SH_RD;
            end

            // Hand the result to the output register when it frees up
            S_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = after_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            after_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

endmodule
